/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent in the same cycle
`define BBA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// antecedent true implies consequent in the next cycle
`define BBA_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* design/bba_pkg.sv */
// package: sizes, codes, structs and helper functions of the buddy allocator
package bba_pkg;

   localparam int HEAP_BYTES      = 65536;
   localparam int MIN_ORDER_SHIFT = 5;
   localparam int NUM_ORDERS      = 11;
   localparam int HEADER_BYTES    = 24;

   localparam int TOP_ORDER = NUM_ORDERS - 1;
   localparam int TOP_SHIFT = MIN_ORDER_SHIFT + TOP_ORDER;
   localparam int GRANULES  = HEAP_BYTES >> MIN_ORDER_SHIFT;
   localparam int TOP_COUNT = HEAP_BYTES >> TOP_SHIFT;
   localparam int GR_AW     = $clog2(GRANULES);
   localparam int WORD_W    = 32;
   localparam int WORD_SH   = 5;
   localparam int ORD_W     = 4;
   localparam int OFF_W     = 16;
   localparam int BYTES_W   = 15;
   localparam int NEED_W    = 17;
   localparam int GT_W      = 5;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOMEM   = 2'd1,
      ST_TOOBIG  = 2'd2,
      ST_BADFREE = 2'd3
   } status_type;

   // first bitmap word of an order; each order starts on a word of its own
   function automatic int word_base(input int o);
      int b;
      b = 0;
      for (int j = 0; j < NUM_ORDERS; j++) begin
         if (j < o) begin
            b += ((GRANULES >> j) + WORD_W - 1) >> WORD_SH;
         end
      end
      return b;
   endfunction

   localparam int BM_WORDS = word_base(NUM_ORDERS);
   localparam int BM_AW    = $clog2(BM_WORDS);
   localparam int SCAN_W   = $clog2(BM_WORDS + 1);

   typedef struct packed {
      logic              we;
      logic [BM_AW-1:0]  addr;
      logic [WORD_W-1:0] wdata;
   } bm_req_type;

   typedef struct packed {
      logic             we;
      logic [GR_AW-1:0] addr;
      logic [GT_W-1:0]  wdata;
   } gt_req_type;

   // bitmap word that holds the free bit of block idx of order ord
   function automatic logic [BM_AW-1:0] bit_word(input logic [ORD_W-1:0] ord,
                                                 input logic [GR_AW-1:0] idx);
      int w;
      w = word_base(int'(ord)) + int'(idx >> WORD_SH);
      return BM_AW'(w);
   endfunction

   function automatic logic [ORD_W-1:0] order_of_word(input logic [BM_AW-1:0] a);
      logic [ORD_W-1:0] k;
      k = '0;
      for (int j = 0; j < NUM_ORDERS; j++) begin
         if (int'(a) >= word_base(j)) begin
            k = ORD_W'(j);
         end
      end
      return k;
   endfunction

   // reset content of a bitmap word: only the top-order blocks free
   function automatic logic [WORD_W-1:0] init_word(input logic [BM_AW-1:0] a);
      logic [WORD_W-1:0] w;
      int rel;
      w = '0;
      rel = int'(a) - word_base(TOP_ORDER);
      for (int j = 0; j < WORD_W; j++) begin
         if (rel >= 0 && rel * WORD_W + j < TOP_COUNT) begin
            w[j] = 1'b1;
         end
      end
      return w;
   endfunction

   function automatic logic [WORD_SH-1:0] first_set(input logic [WORD_W-1:0] d);
      logic [WORD_SH-1:0] p;
      p = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (d[j]) begin
            p = WORD_SH'(j);
         end
      end
      return p;
   endfunction

endpackage

/* design/bba_ram.sv */
// single-port synchronous ram with registered read data
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/bba_ctrl.sv */
// sequencer: scan, split, merge and clear pass over the two memories
module bba_ctrl
   import bba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_command,
   input  logic [BYTES_W-1:0] req_request_bytes,
   input  logic [OFF_W-1:0]   req_block_offset,
   output logic               busy,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [OFF_W-1:0]   rsp_user_offset,
   output logic [ORD_W-1:0]   rsp_block_order,
   output bm_req_type         bm_req,
   input  logic [WORD_W-1:0]  bm_rdata,
   output gt_req_type         gt_req,
   input  logic [GT_W-1:0]    gt_rdata
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_SPLIT_RD, S_SPLIT_WR, S_MARK,
      S_FCHK, S_BUD_RD, S_BUD_CHK, S_SET_RD, S_SET_WR
   } state_type;

   state_type        state_ff, state_in;
   logic [GR_AW-1:0] clr_ff, clr_in;
   logic [ORD_W-1:0] fit_ff, fit_in;
   logic [ORD_W-1:0] ord_ff, ord_in;
   logic [GR_AW-1:0] idx_ff, idx_in;
   logic [GR_AW-1:0] g_ff, g_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [BM_AW-1:0] chk_ff, chk_in;
   logic             pend_ff, pend_in;
   logic             done_ff, done_in;
   status_type       status_ff, status_in;
   logic [OFF_W-1:0] uoff_ff, uoff_in;
   logic [ORD_W-1:0] bord_ff, bord_in;

   logic [NEED_W-1:0]  need;
   logic [ORD_W-1:0]   fit;
   logic [OFF_W-1:0]   faddr;
   logic [ORD_W-1:0]   k;
   logic [WORD_SH-1:0] bp;
   logic [GR_AW-1:0]   gran;
   logic [GR_AW-1:0]   p;
   logic               found;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      fit_in    = fit_ff;
      ord_in    = ord_ff;
      idx_in    = idx_ff;
      g_in      = g_ff;
      scan_in   = scan_ff;
      chk_in    = chk_ff;
      pend_in   = pend_ff;
      done_in   = 1'b0;
      status_in = status_ff;
      uoff_in   = uoff_ff;
      bord_in   = bord_ff;
      bm_req    = '0;
      gt_req    = '0;

      need = NEED_W'(req_request_bytes) + NEED_W'(HEADER_BYTES);
      fit = '0;
      for (int j = NUM_ORDERS - 1; j >= 0; j--) begin
         if ((NEED_W'(1) << (MIN_ORDER_SHIFT + j)) >= need) begin
            fit = ORD_W'(j);
         end
      end
      faddr = req_block_offset - OFF_W'(HEADER_BYTES);
      found = pend_ff && (bm_rdata != '0);
      k     = order_of_word(chk_ff);
      bp    = first_set(bm_rdata);
      gran  = GR_AW'(idx_ff << fit_ff);
      p     = idx_ff | GR_AW'(1);

      case (state_ff)
         S_CLEAR: begin
            bm_req.we    = (int'(clr_ff) < BM_WORDS);
            bm_req.addr  = BM_AW'(clr_ff);
            bm_req.wdata = init_word(BM_AW'(clr_ff));
            gt_req.we    = 1'b1;
            gt_req.addr  = clr_ff;
            clr_in       = clr_ff + GR_AW'(1);
            if (clr_ff == GR_AW'(GRANULES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               uoff_in = '0;
               bord_in = '0;
               if (req_command == CMD_ALLOC) begin
                  if (need > (NEED_W'(1) << TOP_SHIFT)) begin
                     done_in   = 1'b1;
                     status_in = ST_TOOBIG;
                  end else begin
                     fit_in   = fit;
                     scan_in  = SCAN_W'(word_base(int'(fit)));
                     pend_in  = 1'b0;
                     state_in = S_SCAN;
                  end
               end else begin
                  if (req_block_offset < OFF_W'(HEADER_BYTES) ||
                      faddr[MIN_ORDER_SHIFT-1:0] != '0 ||
                      int'(faddr >> MIN_ORDER_SHIFT) >= GRANULES) begin
                     done_in   = 1'b1;
                     status_in = ST_BADFREE;
                  end else begin
                     gt_req.addr = GR_AW'(faddr >> MIN_ORDER_SHIFT);
                     g_in        = GR_AW'(faddr >> MIN_ORDER_SHIFT);
                     state_in    = S_FCHK;
                  end
               end
            end
         end
         S_SCAN: begin
            if (found) begin
               // take the lowest free block and clear its bit
               bm_req.we    = 1'b1;
               bm_req.addr  = chk_ff;
               bm_req.wdata = bm_rdata & ~(WORD_W'(1) << bp);
               ord_in       = k;
               idx_in       = GR_AW'((int'(chk_ff) - word_base(int'(k))) * WORD_W) |
                              GR_AW'(bp);
               state_in     = (k == fit_ff) ? S_MARK : S_SPLIT_RD;
            end else if (int'(scan_ff) >= BM_WORDS) begin
               done_in   = 1'b1;
               status_in = ST_NOMEM;
               state_in  = S_IDLE;
            end else begin
               bm_req.addr = scan_ff[BM_AW-1:0];
               chk_in      = scan_ff[BM_AW-1:0];
               pend_in     = 1'b1;
               scan_in     = scan_ff + SCAN_W'(1);
            end
         end
         S_SPLIT_RD: begin
            // keep the lower half, the upper half becomes free
            bm_req.addr = bit_word(ord_ff - ORD_W'(1), (idx_ff << 1) | GR_AW'(1));
            ord_in      = ord_ff - ORD_W'(1);
            idx_in      = idx_ff << 1;
            state_in    = S_SPLIT_WR;
         end
         S_SPLIT_WR: begin
            bm_req.we    = 1'b1;
            bm_req.addr  = bit_word(ord_ff, p);
            bm_req.wdata = bm_rdata | (WORD_W'(1) << p[WORD_SH-1:0]);
            state_in     = (ord_ff == fit_ff) ? S_MARK : S_SPLIT_RD;
         end
         S_MARK: begin
            gt_req.we    = 1'b1;
            gt_req.addr  = gran;
            gt_req.wdata = {1'b1, fit_ff};
            done_in      = 1'b1;
            status_in    = ST_OK;
            uoff_in      = OFF_W'((int'(gran) << MIN_ORDER_SHIFT) + HEADER_BYTES);
            bord_in      = fit_ff;
            state_in     = S_IDLE;
         end
         S_FCHK: begin
            if (!gt_rdata[GT_W-1] || gt_rdata[ORD_W-1:0] > ORD_W'(TOP_ORDER)) begin
               done_in   = 1'b1;
               status_in = ST_BADFREE;
               state_in  = S_IDLE;
            end else begin
               gt_req.we   = 1'b1;
               gt_req.addr = g_ff;
               ord_in      = gt_rdata[ORD_W-1:0];
               idx_in      = g_ff >> gt_rdata[ORD_W-1:0];
               state_in    = (gt_rdata[ORD_W-1:0] < ORD_W'(TOP_ORDER)) ? S_BUD_RD
                                                                        : S_SET_RD;
            end
         end
         S_BUD_RD: begin
            // buddy shares the word of the block
            bm_req.addr = bit_word(ord_ff, idx_ff);
            state_in    = S_BUD_CHK;
         end
         S_BUD_CHK: begin
            bm_req.addr = bit_word(ord_ff, idx_ff);
            if (bm_rdata[idx_ff[WORD_SH-1:0] ^ WORD_SH'(1)]) begin
               bm_req.we    = 1'b1;
               bm_req.wdata = bm_rdata &
                              ~(WORD_W'(1) << (idx_ff[WORD_SH-1:0] ^ WORD_SH'(1)));
               idx_in       = idx_ff >> 1;
               ord_in       = ord_ff + ORD_W'(1);
               state_in     = (ord_ff + ORD_W'(1) < ORD_W'(TOP_ORDER)) ? S_BUD_RD
                                                                       : S_SET_RD;
            end else begin
               state_in = S_SET_RD;
            end
         end
         S_SET_RD: begin
            bm_req.addr = bit_word(ord_ff, idx_ff);
            state_in    = S_SET_WR;
         end
         S_SET_WR: begin
            bm_req.we    = 1'b1;
            bm_req.addr  = bit_word(ord_ff, idx_ff);
            bm_req.wdata = bm_rdata | (WORD_W'(1) << idx_ff[WORD_SH-1:0]);
            done_in      = 1'b1;
            status_in    = ST_OK;
            bord_in      = ord_ff;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
      end
      fit_ff    <= fit_in;
      ord_ff    <= ord_in;
      idx_ff    <= idx_in;
      g_ff      <= g_in;
      scan_ff   <= scan_in;
      chk_ff    <= chk_in;
      status_ff <= status_in;
      uoff_ff   <= uoff_in;
      bord_ff   <= bord_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = done_ff;
   assign rsp_status      = status_ff;
   assign rsp_user_offset = uoff_ff;
   assign rsp_block_order = bord_ff;

endmodule

/* design/buddy_block_allocator_unit.sv */
// top level of the buddy allocator: sequencer plus bitmap and granule memories
//
//  channel  | ports                                         | handshake
//  request  | req_command, req_request_bytes, req_block_offset | start & !busy
//  response | rsp_status, rsp_user_offset, rsp_block_order  | one-cycle rsp_valid
//
// after reset a clearing pass over both memories runs with busy high.
// allocate: a start step, a scan of the bitmap words from the fitting order up
// (up to 131 words) plus a test of the last word read, then a bitmap read and
// write per split level and a granule write to mark the head; the bitmap has one port.
// free: a granule read to check the head, a bitmap read and test per buddy checked
// and a bitmap read and write to set the final free bit. rsp_valid comes the cycle
// after the last step, busy drops in that same cycle; results cannot be stalled.
module buddy_block_allocator_unit
   import bba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_command,
   input  logic [BYTES_W-1:0] req_request_bytes,
   input  logic [OFF_W-1:0]   req_block_offset,
   output logic               busy,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [OFF_W-1:0]   rsp_user_offset,
   output logic [ORD_W-1:0]   rsp_block_order
);

   bm_req_type        bm_req;
   gt_req_type        gt_req;
   logic [WORD_W-1:0] bm_rdata;
   logic [GT_W-1:0]   gt_rdata;

   bba_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_command       (req_command),
      .req_request_bytes (req_request_bytes),
      .req_block_offset  (req_block_offset),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_user_offset   (rsp_user_offset),
      .rsp_block_order   (rsp_block_order),
      .bm_req            (bm_req),
      .bm_rdata          (bm_rdata),
      .gt_req            (gt_req),
      .gt_rdata          (gt_rdata)
   );

   bba_ram #(.WIDTH(WORD_W), .DEPTH(BM_WORDS)) u_bitmap (
      .clock (clock),
      .we    (bm_req.we),
      .addr  (bm_req.addr),
      .wdata (bm_req.wdata),
      .rdata (bm_rdata)
   );

   bba_ram #(.WIDTH(GT_W), .DEPTH(GRANULES)) u_granule (
      .clock (clock),
      .we    (gt_req.we),
      .addr  (gt_req.addr),
      .wdata (gt_req.wdata),
      .rdata (gt_rdata)
   );

endmodule

/* design/bba_checker.sv */
// port-level checker of the buddy allocator and its bind
`include "assert_macros.svh"

module bba_checker
   import bba_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [1:0]         rsp_status,
   input logic [OFF_W-1:0]   rsp_user_offset,
   input logic [ORD_W-1:0]   rsp_block_order
);

   // an accepted request raises busy, or an early reject answers with rsp_valid without raising busy
   `BBA_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy || rsp_valid)
   `BBA_ASSERT_IMP(a_word_idle, clock, reset, rsp_valid, !busy)
   `BBA_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_user_offset == '0 && rsp_block_order == '0)
   `BBA_ASSERT_IMP(a_order_range, clock, reset, rsp_valid, rsp_block_order <= ORD_W'(TOP_ORDER))

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_user_offset (rsp_user_offset),
   .rsp_block_order (rsp_block_order)
);
